// File: rtl/core/ovsw_pkg.sv
// Shared widths, defaults and stage payload types for the overlay scaler window setup.
// No dependencies.
package ovsw_pkg;

  localparam int unsigned SrcW       = 11;
  localparam int unsigned DstPosW    = 13;
  localparam int unsigned DstSizeW   = 12;
  localparam int unsigned StartW     = 15;
  localparam int unsigned StepW      = 32;
  localparam int unsigned OriginFrac = 4;
  localparam int unsigned ProdW      = DstPosW + SrcW;
  localparam int unsigned ClipNumW   = ProdW + OriginFrac;
  localparam int unsigned StepFracDefault = 20;

  typedef struct packed {
    logic                       neg;
    logic [DstSizeW-1:0]        dsize;
    logic signed [DstPosW-1:0]  dpos;
    logic [SrcW-1:0]            spos;
    logic [SrcW-1:0]            ssize;
    logic [SrcW-1:0]            frame;
    logic                       flag;
  } ovsw_axis_t;

  typedef struct packed {
    logic [SrcW-1:0]     frame_width;
    logic [SrcW-1:0]     frame_height;
    logic [StartW-1:0]   start_s;
    logic [StartW-1:0]   start_t;
    logic [DstSizeW-1:0] out_left;
    logic [DstSizeW-1:0] out_top;
    logic [DstSizeW-1:0] out_wide;
    logic [DstSizeW-1:0] out_tall;
    logic                visible;
  } ovsw_geom_t;

endpackage

// File: rtl/core/ovsw_req_if.sv
// Request and result channel interfaces of the overlay scaler window setup.
// Depends on ovsw_pkg.
interface ovsw_req_if import ovsw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SrcW-1:0]            frame_width;
  logic [SrcW-1:0]            frame_height;
  logic [SrcW-1:0]            src_left;
  logic [SrcW-1:0]            src_top;
  logic [SrcW-1:0]            src_wide;
  logic [SrcW-1:0]            src_tall;
  logic signed [DstPosW-1:0]  dst_left;
  logic signed [DstPosW-1:0]  dst_top;
  logic [DstSizeW-1:0]        dst_wide;
  logic [DstSizeW-1:0]        dst_tall;
  logic                       deinterlace;
  logic                       visible;

  modport source (output valid, frame_width, frame_height, src_left, src_top, src_wide,
                  src_tall, dst_left, dst_top, dst_wide, dst_tall, deinterlace, visible,
                  input ready);
  modport sink (input valid, frame_width, frame_height, src_left, src_top, src_wide,
                src_tall, dst_left, dst_top, dst_wide, dst_tall, deinterlace, visible,
                output ready);
endinterface

interface ovsw_rsp_if import ovsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SrcW-1:0]     in_width;
  logic [SrcW-1:0]     in_height;
  logic [StartW-1:0]   start_s;
  logic [StartW-1:0]   start_t;
  logic [StepW-1:0]    step_s;
  logic [StepW-1:0]    step_t;
  logic [DstSizeW-1:0] out_left;
  logic [DstSizeW-1:0] out_top;
  logic [DstSizeW-1:0] out_wide;
  logic [DstSizeW-1:0] out_tall;
  logic                geometry_ok;
  logic                stop_overlay;

  modport source (output valid, in_width, in_height, start_s, start_t, step_s, step_t,
                  out_left, out_top, out_wide, out_tall, geometry_ok, stop_overlay,
                  input ready);
  modport sink (input valid, in_width, in_height, start_s, start_t, step_s, step_t,
                out_left, out_top, out_wide, out_tall, geometry_ok, stop_overlay,
                output ready);
endinterface

// File: rtl/core/ovsw_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// No package dependencies.
module ovsw_div_pipe #(
  parameter int unsigned NumW  = 28,
  parameter int unsigned DenW  = 12,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             valid_q [NumW];
  logic [NumW-1:0]  nq_q    [NumW];
  logic [DenW-1:0]  rem_q   [NumW];
  logic [DenW-1:0]  den_q   [NumW];
  logic [SideW-1:0] side_q  [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             v_in;
    logic [NumW-1:0]  nq_in;
    logic [DenW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, nq_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]   <= {nq_in[NumW-2:0], ge};
        rem_q[k]  <= ge ? DenW'(trial - {1'b0, den_in}) : trial[DenW-1:0];
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NumW-1];
  assign quo_o   = nq_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

// File: rtl/core/overlay_scaler_window_setup_unit.sv
// Top level of the overlay scaler window setup: clipping, deinterlace and step computation.
// Depends on ovsw_pkg, ovsw_req_if, ovsw_rsp_if and ovsw_div_pipe.

// The unit takes one overlay request per cycle while no result waits, and returns one result
// per request, in order. Each request passes the clip multiply register, the clip divider,
// the clipping register, the step divider and the output register, in that order. The whole
// pipeline stalls while a result waits.
module overlay_scaler_window_setup_unit import ovsw_pkg::*; #(
  parameter int unsigned STEP_FRACTION_BITS = StepFracDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ovsw_req_if.sink   req_i,
  ovsw_rsp_if.source rsp_o
);

  localparam int unsigned StepNumW = SrcW + STEP_FRACTION_BITS;

  logic en;
  logic out_valid_q;

  assign en        = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // Multiply stage.
  logic             s1_valid_q;
  logic [ProdW-1:0] s1_px_q, s1_py_q;
  ovsw_axis_t       s1_x_q, s1_y_q;
  logic [DstPosW-1:0] magx, magy;

  assign magx = DstPosW'(-req_i.dst_left);
  assign magy = DstPosW'(-req_i.dst_top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_px_q <= {{(ProdW-DstPosW){1'b0}}, magx} * {{(ProdW-SrcW){1'b0}}, req_i.src_wide};
      s1_py_q <= {{(ProdW-DstPosW){1'b0}}, magy} * {{(ProdW-SrcW){1'b0}}, req_i.src_tall};
      s1_x_q  <= '{neg: req_i.dst_left[DstPosW-1], dsize: req_i.dst_wide,
                   dpos: req_i.dst_left, spos: req_i.src_left, ssize: req_i.src_wide,
                   frame: req_i.frame_width, flag: req_i.visible};
      s1_y_q  <= '{neg: req_i.dst_top[DstPosW-1], dsize: req_i.dst_tall,
                   dpos: req_i.dst_top, spos: req_i.src_top, ssize: req_i.src_tall,
                   frame: req_i.frame_height, flag: req_i.deinterlace};
    end
  end

  // Clip dividers.
  logic                cx_valid, cy_valid;
  logic [ClipNumW-1:0] qx, qy;
  ovsw_axis_t          cx, cy;

  ovsw_div_pipe #(.NumW(ClipNumW), .DenW(DstSizeW), .SideW($bits(ovsw_axis_t))) u_clip_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_valid_q),
    .num_i({s1_px_q, {OriginFrac{1'b0}}}), .den_i(s1_x_q.dsize), .side_i(s1_x_q),
    .valid_o(cx_valid), .quo_o(qx), .side_o(cx)
  );

  ovsw_div_pipe #(.NumW(ClipNumW), .DenW(DstSizeW), .SideW($bits(ovsw_axis_t))) u_clip_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_valid_q),
    .num_i({s1_py_q, {OriginFrac{1'b0}}}), .den_i(s1_y_q.dsize), .side_i(s1_y_q),
    .valid_o(cy_valid), .quo_o(qy), .side_o(cy)
  );

  // Clip stage.
  localparam int unsigned TrimW = ClipNumW - OriginFrac;
  localparam int unsigned SizeW = TrimW + 2;

  logic signed [SizeW-1:0]      sw_n, sh_n, sh_h;
  logic signed [DstSizeW+1:0]   dw_n, dh_n;
  logic [StartW:0]              sx16, sy16;
  logic                         ok_n;

  always_comb begin
    sw_n = $signed({{(SizeW-SrcW){1'b0}}, cx.ssize})
         - $signed({2'b00, cx.neg ? qx[ClipNumW-1:OriginFrac] : {TrimW{1'b0}}});
    sh_n = $signed({{(SizeW-SrcW){1'b0}}, cy.ssize})
         - $signed({2'b00, cy.neg ? qy[ClipNumW-1:OriginFrac] : {TrimW{1'b0}}});
    sh_h = cy.flag ? (sh_n >>> 1) : sh_n;
    dw_n = cx.neg ? $signed({2'b00, cx.dsize}) + $signed({cx.dpos[DstPosW-1], cx.dpos})
                  : $signed({2'b00, cx.dsize});
    dh_n = cy.neg ? $signed({2'b00, cy.dsize}) + $signed({cy.dpos[DstPosW-1], cy.dpos})
                  : $signed({2'b00, cy.dsize});
    sx16 = {1'b0, cx.spos, {OriginFrac{1'b0}}} + (cx.neg ? qx[StartW:0] : '0);
    sy16 = {1'b0, cy.spos, {OriginFrac{1'b0}}} + (cy.neg ? qy[StartW:0] : '0);
    ok_n = !(cx.neg && cx.dsize == '0) && !(cy.neg && cy.dsize == '0)
        && (sw_n > 0) && (sh_h > 0) && (dw_n > 0) && (dh_n > 0);
  end

  logic                c_valid_q, c_ok_q;
  logic [SrcW-1:0]     c_sw_q, c_sh_q;
  logic [DstSizeW-1:0] c_dw_q, c_dh_q;
  ovsw_geom_t          c_geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= cx_valid && cy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ok_q <= ok_n;
      c_sw_q <= sw_n[SrcW-1:0];
      c_sh_q <= sh_h[SrcW-1:0];
      c_dw_q <= dw_n[DstSizeW-1:0];
      c_dh_q <= dh_n[DstSizeW-1:0];
      c_geom_q.frame_width  <= cx.frame;
      c_geom_q.frame_height <= cy.flag ? {1'b0, cy.frame[SrcW-1:1]} : cy.frame;
      c_geom_q.start_s      <= sx16[StartW-1:0];
      c_geom_q.start_t      <= cy.flag ? sy16[StartW:1] : sy16[StartW-1:0];
      c_geom_q.out_left     <= cx.neg ? '0 : cx.dpos[DstSizeW-1:0];
      c_geom_q.out_top      <= cy.neg ? '0 : cy.dpos[DstSizeW-1:0];
      c_geom_q.out_wide     <= dw_n[DstSizeW-1:0];
      c_geom_q.out_tall     <= dh_n[DstSizeW-1:0];
      c_geom_q.visible      <= cx.flag;
    end
  end

  // Step dividers.
  logic                sx_valid, sy_valid, st_ok;
  logic [StepNumW-1:0] qs, qt;
  ovsw_geom_t          st_geom;

  ovsw_div_pipe #(.NumW(StepNumW), .DenW(DstSizeW), .SideW($bits(ovsw_geom_t))) u_step_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_valid_q),
    .num_i({c_sw_q, {STEP_FRACTION_BITS{1'b0}}}), .den_i(c_dw_q), .side_i(c_geom_q),
    .valid_o(sx_valid), .quo_o(qs), .side_o(st_geom)
  );

  ovsw_div_pipe #(.NumW(StepNumW), .DenW(DstSizeW), .SideW(1)) u_step_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_valid_q),
    .num_i({c_sh_q, {STEP_FRACTION_BITS{1'b0}}}), .den_i(c_dh_q), .side_i(c_ok_q),
    .valid_o(sy_valid), .quo_o(qt), .side_o(st_ok)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sx_valid && sy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_o.in_width     <= st_ok ? st_geom.frame_width  : '0;
      rsp_o.in_height    <= st_ok ? st_geom.frame_height : '0;
      rsp_o.start_s      <= st_ok ? st_geom.start_s      : '0;
      rsp_o.start_t      <= st_ok ? st_geom.start_t      : '0;
      rsp_o.step_s       <= st_ok ? StepW'(qs)           : '0;
      rsp_o.step_t       <= st_ok ? StepW'(qt)           : '0;
      rsp_o.out_left     <= st_ok ? st_geom.out_left     : '0;
      rsp_o.out_top      <= st_ok ? st_geom.out_top      : '0;
      rsp_o.out_wide     <= st_ok ? st_geom.out_wide     : '0;
      rsp_o.out_tall     <= st_ok ? st_geom.out_tall     : '0;
      rsp_o.geometry_ok  <= st_ok;
      rsp_o.stop_overlay <= !st_ok || !st_geom.visible;
    end
  end

  assign rsp_o.valid = out_valid_q;

endmodule

// File: tb/sv/overlay_scaler_window_setup_unit_tb.sv
// Testbench for the overlay scaler window setup unit: drives overlay requests with random
// idling and stalls and checks every result against an internal window-setup predictor.
// Depends on ovsw_pkg, ovsw_req_if, ovsw_rsp_if and the unit itself.
module overlay_scaler_window_setup_unit_tb;
  import ovsw_pkg::*;

  localparam int unsigned StepFrac = StepFracDefault;
  localparam int unsigned Latency = 42 + StepFrac;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [SrcW-1:0]           frame_width;
    logic [SrcW-1:0]           frame_height;
    logic [SrcW-1:0]           src_left;
    logic [SrcW-1:0]           src_top;
    logic [SrcW-1:0]           src_wide;
    logic [SrcW-1:0]           src_tall;
    logic signed [DstPosW-1:0] dst_left;
    logic signed [DstPosW-1:0] dst_top;
    logic [DstSizeW-1:0]       dst_wide;
    logic [DstSizeW-1:0]       dst_tall;
    logic                      deinterlace;
    logic                      visible;
  } overlay_req_t;

  typedef struct packed {
    logic [SrcW-1:0]     in_width;
    logic [SrcW-1:0]     in_height;
    logic [StartW-1:0]   start_s;
    logic [StartW-1:0]   start_t;
    logic [StepW-1:0]    step_s;
    logic [StepW-1:0]    step_t;
    logic [DstSizeW-1:0] out_left;
    logic [DstSizeW-1:0] out_top;
    logic [DstSizeW-1:0] out_wide;
    logic [DstSizeW-1:0] out_tall;
    logic                geometry_ok;
    logic                stop_overlay;
  } window_setup_t;

  class window_scoreboard;
    window_setup_t pending_setups[$];
    int errors;
    int checked;
    int rejected;

    function window_setup_t compute_setup(overlay_req_t r);
      window_setup_t s;
      longint fh, sx, sy, sw, sh, dx, dy, dw, dh;
      logic ok;
      fh = r.frame_height;
      sx = r.src_left * 16;
      sy = r.src_top * 16;
      sw = r.src_wide;
      sh = r.src_tall;
      dx = r.dst_left;
      dy = r.dst_top;
      dw = r.dst_wide;
      dh = r.dst_tall;
      ok = 1'b1;
      if (dx < 0) begin
        if (dw == 0) begin
          ok = 1'b0;
        end else begin
          sx = sx - (dx * sw * 16) / dw;
          sw = sw + (dx * sw) / dw;
          dw = dw + dx;
          dx = 0;
        end
      end
      if (dy < 0) begin
        if (dh == 0) begin
          ok = 1'b0;
        end else begin
          sy = sy - (dy * sh * 16) / dh;
          sh = sh + (dy * sh) / dh;
          dh = dh + dy;
          dy = 0;
        end
      end
      if (r.deinterlace) begin
        fh = fh / 2;
        sy = sy / 2;
        sh = sh / 2;
      end
      if (sw < 1 || sh < 1 || dw < 1 || dh < 1) ok = 1'b0;
      s = '0;
      if (!ok) begin
        s.stop_overlay = 1'b1;
        return s;
      end
      s.in_width = r.frame_width;
      s.in_height = fh[SrcW-1:0];
      s.start_s = sx[StartW-1:0];
      s.start_t = sy[StartW-1:0];
      s.step_s = StepW'((sw << StepFrac) / dw);
      s.step_t = StepW'((sh << StepFrac) / dh);
      s.out_left = dx[DstSizeW-1:0];
      s.out_top = dy[DstSizeW-1:0];
      s.out_wide = dw[DstSizeW-1:0];
      s.out_tall = dh[DstSizeW-1:0];
      s.geometry_ok = 1'b1;
      s.stop_overlay = !r.visible;
      return s;
    endfunction

    function void note_request(overlay_req_t r);
      window_setup_t s;
      s = compute_setup(r);
      if (!s.geometry_ok) rejected++;
      pending_setups.push_back(s);
    endfunction

    function void check_setup(window_setup_t got);
      window_setup_t exp_s;
      if (pending_setups.size() == 0) begin
        $display("%0t: result with none outstanding: %p", $time, got);
        errors++;
        return;
      end
      exp_s = pending_setups.pop_front();
      checked++;
      if (got !== exp_s) begin
        errors++;
        $display("%0t: mismatch", $time);
        $display("  expected %p", exp_s);
        $display("  actual   %p", got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;
  window_scoreboard board;

  ovsw_req_if req_if ();
  ovsw_rsp_if rsp_if ();

  overlay_scaler_window_setup_unit #(.STEP_FRACTION_BITS(StepFrac)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      board.check_setup('{rsp_if.in_width, rsp_if.in_height, rsp_if.start_s, rsp_if.start_t,
                          rsp_if.step_s, rsp_if.step_t, rsp_if.out_left, rsp_if.out_top,
                          rsp_if.out_wide, rsp_if.out_tall, rsp_if.geometry_ok,
                          rsp_if.stop_overlay});
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(overlay_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.frame_width <= r.frame_width;
    req_if.frame_height <= r.frame_height;
    req_if.src_left <= r.src_left;
    req_if.src_top <= r.src_top;
    req_if.src_wide <= r.src_wide;
    req_if.src_tall <= r.src_tall;
    req_if.dst_left <= r.dst_left;
    req_if.dst_top <= r.dst_top;
    req_if.dst_wide <= r.dst_wide;
    req_if.dst_tall <= r.dst_tall;
    req_if.deinterlace <= r.deinterlace;
    req_if.visible <= r.visible;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (board.pending_setups.size() != 0) @(negedge clk_i);
  endtask

  function automatic overlay_req_t random_request();
    overlay_req_t r;
    int unsigned mode;
    r = $bits(overlay_req_t)'({$urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(9);
    if (mode < 7) begin
      // Mostly plausible windows: nonzero sizes and modest negative offsets.
      r.src_wide = SrcW'($urandom_range(2047, 1));
      r.src_tall = SrcW'($urandom_range(2047, 1));
      r.dst_wide = DstSizeW'($urandom_range(4095, 1));
      r.dst_tall = DstSizeW'($urandom_range(4095, 1));
      if ($urandom_range(1)) r.dst_left = -$signed(13'($urandom_range(r.dst_wide, 0)));
      if ($urandom_range(1)) r.dst_top = -$signed(13'($urandom_range(r.dst_tall, 0)));
      if (mode < 3) begin
        r.dst_wide = DstSizeW'($urandom_range(64, 1));
        r.dst_tall = DstSizeW'($urandom_range(64, 1));
      end
    end
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    overlay_req_t r;
    board = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    rsp_if.ready = 1'b0;
    r = '0;
    {req_if.frame_width, req_if.frame_height, req_if.src_left, req_if.src_top,
     req_if.src_wide, req_if.src_tall, req_if.dst_left, req_if.dst_top, req_if.dst_wide,
     req_if.dst_tall, req_if.deinterlace, req_if.visible} = r;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Plain window, then extremes of each field.
    send_request('{640, 480, 0, 0, 640, 480, 0, 0, 640, 480, 0, 1});
    send_request('{2047, 2047, 2047, 2047, 2047, 2047, 4095, 4095, 4095, 4095, 1, 1});
    send_request('{1, 1, 0, 0, 1, 1, 0, 0, 1, 1, 0, 1});
    send_request('{1, 1, 0, 0, 2047, 2047, 0, 0, 1, 1, 0, 1});
    send_request('{0, 0, 5, 5, 10, 10, 3, 3, 20, 20, 0, 1});
    // Negative position with zero screen size, horizontal then vertical.
    send_request('{100, 100, 0, 0, 50, 50, -10, 0, 0, 40, 0, 1});
    send_request('{100, 100, 0, 0, 50, 50, 0, -10, 40, 0, 0, 1});
    // Clipping with proportional trimming, and full clip-off.
    send_request('{720, 576, 16, 8, 720, 576, -100, -50, 800, 600, 0, 1});
    send_request('{720, 576, 0, 0, 720, 576, -4096, -4096, 4095, 4095, 0, 1});
    send_request('{720, 576, 0, 0, 720, 576, -800, 0, 800, 600, 0, 1});
    send_request('{720, 576, 2047, 2047, 3, 3, -1, -1, 4095, 4095, 0, 1});
    // Deinterlace, including a height that halves to zero.
    send_request('{720, 577, 3, 7, 720, 575, 10, 10, 720, 288, 1, 1});
    send_request('{720, 1, 0, 1, 10, 1, 0, 0, 10, 10, 1, 1});
    // Invisible layer with good and with failed geometry.
    send_request('{320, 240, 1, 1, 100, 100, 4, 4, 200, 200, 0, 0});
    send_request('{320, 240, 1, 1, 0, 100, 4, 4, 200, 200, 0, 0});
    send_request('{320, 240, 1, 1, 100, 100, 4, 4, 0, 0, 1, 0});
    send_request('{2047, 2047, 0, 0, 2047, 2047, -1, -1, 1, 1, 0, 1});
    drain_results();

    run_random(100);
    send_idle_pct = 52;
    run_random(100);
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    run_random(100);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    run_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(50);
    drain_results();
    repeat (Latency + 20) @(negedge clk_i);

    $display("Checked %0d window setups, %0d of them with rejected geometry.",
             board.checked, board.rejected);
    if (board.errors == 0 && board.pending_setups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
